### hw/rtl/assert_macros.svh
// Assertion macros used by the checker of the hash table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lpht_pkg.sv
// Package with the status codes, field widths and hash functions of the hash table unit.
`default_nettype none

package lpht_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 6;
    localparam int LIMIT_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        OP_SET = 1'b0,
        OP_GET = 1'b1
    } op_t;

    // First half of the integer bit mix: add, xor, add, xor.
    function automatic logic [31:0] mix_front(input logic [31:0] h);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = ~h + (h << 15);
        b = a ^ (a >> 12);
        c = b + (b << 2);
        return c ^ (c >> 4);
    endfunction

    // Second half: multiply by 2057 as shifts and adds, then the final xor.
    function automatic logic [31:0] mix_back(input logic [31:0] h);
        logic [31:0] m;
        m = (h << 11) + (h << 3) + h;
        return m ^ (m >> 16);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/linear_probe_hash_table_unit.sv
// Top level of the linear probing hash table unit.
`default_nettype none

// Open-addressing hash map of CAPACITY slots (a power of two) for 32-bit keys.
// Each input transaction is a set (tuser 0) or a get (tuser 1) and yields exactly
// one output transaction with a status, a value and a slot index. The unit works
// on one transaction at a time: after acceptance it passes the second hash stage,
// then probes P slots (P from 1 to CAPACITY), and finishes once the output register
// is free, before the next acceptance; the probe loop reads the key memory once per
// cycle through its single read port. After reset a clearing pass over all CAPACITY
// slots zeroes the occupancy marks before the first input transaction is accepted;
// limit writes are taken at any time.
module linear_probe_hash_table_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          max_entries_wr_en,
    input  wire logic [lpht_pkg::LIMIT_W-1:0]  max_entries_wr_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [63:0]                   s_axis_tdata,  // key[31:0], value[63:32]
    input  wire logic                          s_axis_tuser,  // op[0]
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [39:0]                   m_axis_tdata,  // value_out[31:0], slot_index[37:32]
    output logic      [2:0]                    m_axis_tuser   // status[2:0]
);

    import lpht_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     clear_cnt_reg;
    logic [IDX_W-1:0]     probe_cnt_reg;
    logic [IDX_W-1:0]     idx_reg;
    op_t                  op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [31:0]          hash_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [LIMIT_W-1:0]   max_entries_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [SLOT_W-1:0]    out_slot_reg;

    logic [KEY_W:0]       key_rd_data;
    logic [VALUE_W-1:0]   val_rd_data;
    logic [KEY_W:0]       key_wr_data;
    logic [IDX_W-1:0]     key_wr_addr;
    logic                 key_wr_en;
    logic                 val_wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     hash_idx;
    logic                 slot_empty;
    logic                 slot_hit;
    logic                 probe_last;
    logic                 probe_done;
    logic                 out_free;
    logic                 fire;
    logic                 advance;
    logic                 insert_ok;
    logic                 do_insert;
    logic                 do_update;
    status_t              result_status;
    logic [VALUE_W-1:0]   result_value;
    logic [SLOT_W-1:0]    result_slot;

    assign hash_idx   = IDX_W'(mix_back(hash_reg));
    assign slot_empty = !key_rd_data[KEY_W];
    assign slot_hit   = key_rd_data[KEY_W] && (key_rd_data[KEY_W-1:0] == key_reg);
    assign probe_last = &probe_cnt_reg;
    assign probe_done = slot_empty || slot_hit || probe_last;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign fire       = (state_reg == S_PROBE) && probe_done && out_free;
    assign advance    = (state_reg == S_PROBE) && !probe_done;
    assign insert_ok  = slot_empty && (count_reg < {1'b0, max_entries_reg});
    assign do_update  = fire && (op_reg == OP_SET) && slot_hit;
    assign do_insert  = fire && (op_reg == OP_SET) && !slot_hit && insert_ok;

    assign rd_en   = (state_reg == S_HASH) || advance;
    assign rd_addr = (state_reg == S_HASH) ? hash_idx : idx_reg + 1'b1;

    assign key_wr_en   = (state_reg == S_CLEAR) || do_insert;
    assign key_wr_addr = (state_reg == S_CLEAR) ? clear_cnt_reg : idx_reg;
    assign key_wr_data = (state_reg == S_CLEAR) ? '0 : {1'b1, key_reg};
    assign val_wr_en   = do_update || do_insert;

    always_comb
    begin
        result_status = ST_NOT_FOUND;
        result_value  = '0;
        result_slot   = '0;
        if (op_reg == OP_GET)
        begin
            if (slot_hit)
            begin
                result_status = ST_FOUND;
                result_value  = val_rd_data;
                result_slot   = SLOT_W'(idx_reg);
            end
        end
        else if (slot_hit)
        begin
            result_status = ST_UPDATED;
            result_slot   = SLOT_W'(idx_reg);
        end
        else if (insert_ok)
        begin
            result_status = ST_INSERTED;
            result_slot   = SLOT_W'(idx_reg);
        end
        else
        begin
            result_status = ST_FULL;
        end
    end

    lpht_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rd_data)
    );

    lpht_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (idx_reg),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (val_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clear_cnt_reg   <= '0;
            probe_cnt_reg   <= '0;
            idx_reg         <= '0;
            op_reg          <= OP_SET;
            key_reg         <= '0;
            value_reg       <= '0;
            hash_reg        <= '0;
            count_reg       <= '0;
            max_entries_reg <= LIMIT_W'(48);
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_INSERTED;
            out_value_reg   <= '0;
            out_slot_reg    <= '0;
        end
        else
        begin
            if (max_entries_wr_en)
            begin
                max_entries_reg <= max_entries_wr_data;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + 1'b1;
                    if (&clear_cnt_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg    <= op_t'(s_axis_tuser);
                        key_reg   <= s_axis_tdata[31:0];
                        value_reg <= s_axis_tdata[63:32];
                        hash_reg  <= mix_front(s_axis_tdata[31:0]);
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    idx_reg       <= hash_idx;
                    probe_cnt_reg <= '0;
                    state_reg     <= S_PROBE;
                end
                S_PROBE:
                begin
                    if (advance)
                    begin
                        idx_reg       <= idx_reg + 1'b1;
                        probe_cnt_reg <= probe_cnt_reg + 1'b1;
                    end
                    else if (fire)
                    begin
                        out_status_reg <= result_status;
                        out_value_reg  <= result_value;
                        out_slot_reg   <= result_slot;
                        if (do_insert)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_slot_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

### hw/rtl/lpht_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lpht_checker.sv
// Port-level checker of the hash table unit and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module lpht_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    import lpht_pkg::*;

    `LPHT_ASSERT_NOW(a_status_legal, m_axis_tvalid, m_axis_tuser <= ST_FULL, "Output status code is out of range.")

    `LPHT_ASSERT_NOW(a_miss_is_zero, m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_FULL), m_axis_tdata == 40'd0, "A miss or refusal carries a nonzero value or slot.")

    `LPHT_ASSERT_NOW(a_value_only_found, m_axis_tvalid && m_axis_tuser != ST_FOUND, m_axis_tdata[31:0] == 32'd0, "A value is returned without a found status.")

    `LPHT_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "A second input transaction was taken right after the first.")

    `LPHT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "A stalled output transaction changed.")

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### test/tb.sv
// Testbench for the hash table unit with directed and random set and get traffic.
`timescale 1ns / 1ps

module tb;
    import lpht_pkg::*;

    typedef struct {
        op_t         op;
        logic [31:0] key;
        logic [31:0] value;
    } access_t;

    typedef struct {
        status_t     status;
        logic [31:0] value;
        logic [5:0]  slot;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        max_entries_wr_en = 1'b0;
    logic [5:0]  max_entries_wr_data = 6'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = 64'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    access_t     pending_accesses[$];
    reply_t      expected_replies[$];
    logic [31:0] key_pool[$];

    logic [31:0] model_key[64];
    logic [31:0] model_value[64];
    bit          table_used[64];
    int          live_count = 0;
    int          entry_limit = 48;
    int          mismatches = 0;

    access_t     next_access;
    reply_t      oldest_reply;
    int          burst_left = 1;
    int          gap_left = 0;
    int          ready_mode = 0;
    int          mode_left = 0;
    int          stall_left = 0;

    linear_probe_hash_table_unit DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .max_entries_wr_en   (max_entries_wr_en),
        .max_entries_wr_data (max_entries_wr_data),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [31:0] mix_key(input logic [31:0] k);
        logic [31:0] h;
        h = ~k + (k << 15);
        h = h ^ (h >> 12);
        h = h + (h << 2);
        h = h ^ (h >> 4);
        h = h * 32'd2057;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [31:0] key_homed_at(input int slot);
        logic [31:0] k;
        logic [31:0] h;
        k = $urandom;
        h = mix_key(k);
        while (h[5:0] != slot[5:0])
        begin
            k = $urandom;
            h = mix_key(k);
        end
        return k;
    endfunction

    task automatic predict_access(input op_t op, input logic [31:0] key,
                                  input logic [31:0] value);
        reply_t      r;
        logic [31:0] h;
        logic [5:0]  idx;
        bit          hit;
        bit          hole;
        h = mix_key(key);
        idx = h[5:0];
        hit = 0;
        hole = 0;
        for (int n = 0; n < 64 && !hit && !hole; n++)
        begin
            if (!table_used[idx])
                hole = 1;
            else if (model_key[idx] == key)
                hit = 1;
            else
                idx = idx + 6'd1;
        end
        r.status = ST_NOT_FOUND;
        r.value = '0;
        r.slot = '0;
        if (op == OP_GET)
        begin
            if (hit)
            begin
                r.status = ST_FOUND;
                r.value = model_value[idx];
                r.slot = idx;
            end
        end
        else if (hit)
        begin
            model_value[idx] = value;
            r.status = ST_UPDATED;
            r.slot = idx;
        end
        else if (hole && live_count + 1 <= entry_limit)
        begin
            model_key[idx] = key;
            model_value[idx] = value;
            table_used[idx] = 1;
            live_count = live_count + 1;
            r.status = ST_INSERTED;
            r.slot = idx;
        end
        else
        begin
            r.status = ST_FULL;
        end
        expected_replies.push_back(r);
    endtask

    task automatic queue_access(input op_t op, input logic [31:0] key,
                                input logic [31:0] value);
        access_t a;
        a.op = op;
        a.key = key;
        a.value = value;
        pending_accesses.push_back(a);
        if (op == OP_SET)
            key_pool.push_back(key);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_accesses.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input int limit);
        wait_drained();
        repeat (2) @(posedge clk);
        max_entries_wr_en <= 1'b1;
        max_entries_wr_data <= limit[5:0];
        @(posedge clk);
        max_entries_wr_en <= 1'b0;
        entry_limit = limit;
    endtask

    task automatic run_random_phase(input int count);
        op_t         op;
        logic [31:0] key;
        logic [31:0] value;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 99) < 55) ? OP_SET : OP_GET;
            if (key_pool.size() > 0 && $urandom_range(0, 99) < ((op == OP_SET) ? 55 : 70))
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if ($urandom_range(0, 4) == 0)
                key = key_homed_at($urandom_range(0, 63));
            else
                key = $urandom;
            value = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
            queue_access(op, key, value);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 64'd0;
            s_axis_tuser <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_access(op_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left == 0 && pending_accesses.size() > 0)
                begin
                    next_access = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {next_access.value, next_access.key};
                    s_axis_tuser <= next_access.op;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left = gap_left - 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d", m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    if (m_axis_tuser !== oldest_reply.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest_reply.status, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[31:0] !== oldest_reply.value)
                    begin
                        $error("value_out: expected %h, actual %h",
                               oldest_reply.value, m_axis_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[37:32] !== oldest_reply.slot)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               oldest_reply.slot, m_axis_tdata[37:32]);
                        mismatches++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        m_axis_tready <= 1'b0;
                        stall_left = stall_left - 1;
                    end
                    else
                    begin
                        m_axis_tready <= 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    initial
    begin
        logic [31:0] wrap_a;
        logic [31:0] wrap_b;
        logic [31:0] wrap_c;
        int          limits[8];
        limits = '{12, 5, 30, 63, 1, 48, 0, 63};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        queue_access(OP_GET, 32'h0000_0000, 32'h1111_1111);
        queue_access(OP_SET, 32'h0000_0000, 32'h0000_0000);
        queue_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_access(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_access(OP_SET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_access(OP_SET, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_access(OP_SET, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
        queue_access(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_access(OP_GET, 32'h1234_5678, 32'h0000_0000);

        // Three keys with the last home slot force the probe to wrap around.
        wrap_a = key_homed_at(63);
        wrap_b = key_homed_at(63);
        wrap_c = key_homed_at(63);
        queue_access(OP_SET, wrap_a, $urandom);
        queue_access(OP_SET, wrap_b, $urandom);
        queue_access(OP_SET, wrap_c, $urandom);
        queue_access(OP_GET, wrap_c, 32'h0000_0000);
        queue_access(OP_GET, key_homed_at(63), 32'h0000_0000);

        write_limit(0);
        queue_access(OP_SET, 32'hDEAD_BEEF, 32'h0000_0005);
        queue_access(OP_SET, 32'h0000_0000, 32'h5A5A_5A5A);
        queue_access(OP_GET, 32'hDEAD_BEEF, 32'h0000_0000);
        queue_access(OP_GET, 32'h0000_0000, 32'h0000_0000);

        write_limit(1);
        queue_access(OP_SET, 32'hCAFE_F00D, 32'h0000_0007);
        queue_access(OP_SET, wrap_b, 32'hA5A5_A5A5);
        queue_access(OP_GET, wrap_b, 32'h0000_0000);

        foreach (limits[i])
        begin
            write_limit(limits[i]);
            run_random_phase(85);
        end

        wait_drained();
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
